### rtl/hfr_pkg.sv
// Shared types, constants and the CRC step of the HDLC frame receiver.
package hfr_pkg;

  localparam int unsigned BufBytesDef = 1024;
  localparam int unsigned HdrBytes    = 14;
  localparam int unsigned PrefixDepth = 12;
  localparam int unsigned FifoDepth   = 4;
  localparam int unsigned MinFrame    = 7;

  localparam logic [7:0]  FlagByte    = 8'h7E;
  localparam logic [7:0]  LlcDestByte = 8'hE6;
  localparam logic [7:0]  CtrlSnrm    = 8'h93;
  localparam logic [7:0]  CtrlDisc    = 8'h53;
  localparam logic [7:0]  CtrlUi      = 8'h13;
  localparam logic [15:0] CrcPoly     = 16'h8408;
  localparam logic [15:0] CrcInit     = 16'hFFFF;
  localparam logic [15:0] CrcResidue  = 16'hF0B8;
  localparam logic [3:0]  FormatType  = 4'hA;

  typedef enum logic [2:0] {
    FT_I       = 3'd0,
    FT_SUPER   = 3'd1,
    FT_SNRM    = 3'd2,
    FT_DISC    = 3'd3,
    FT_UI      = 3'd4,
    FT_UNKNOWN = 3'd5
  } ftype_e;

  typedef enum logic {
    KIND_FRAME = 1'b0,
    KIND_READ  = 1'b1
  } kind_e;

  typedef logic [HdrBytes-1:0][7:0]     hdr_t;
  typedef logic [PrefixDepth-1:0][15:0] prefix_t;

  typedef struct packed {
    kind_e       result_kind;
    ftype_e      frame_type;
    logic [14:0] dst_addr;
    logic [6:0]  src_addr;
    logic [7:0]  control;
    logic [2:0]  tx_seq;
    logic [2:0]  rx_seq;
    logic        segmented;
    logic [9:0]  frame_length;
    logic [9:0]  info_start;
    logic [9:0]  info_length;
    logic [7:0]  read_data;
  } result_t;

  // Close event handed from intake to the checker.
  typedef struct packed {
    logic        valid;
    logic [10:0] count;
    logic        crc_ok;
  } close_t;

  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### rtl/hfr_intake.sv
// Byte intake: flag hunting, frame buffer, running CRC and header capture.
module hfr_intake #(
  parameter int unsigned BUF_BYTES = hfr_pkg::BufBytesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic             mode_i,
  input  logic [7:0]       line_byte_i,
  input  logic [9:0]       read_index_i,
  output hfr_pkg::close_t  close_o,
  output hfr_pkg::hdr_t    hdr_o,
  output hfr_pkg::prefix_t prefix_o,
  output logic             rd_valid_o,
  output logic [7:0]       rd_data_o
);

  localparam int unsigned AW = $clog2(BUF_BYTES);
  localparam int unsigned CW = $clog2(BUF_BYTES + 1);

  logic [7:0]  mem_q [BUF_BYTES];
  logic        in_frame_q, in_frame_d;
  logic [CW-1:0] count_q, count_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] crc_next;
  logic        store;
  hfr_pkg::close_t close_q, close_d;
  hfr_pkg::hdr_t    hdr_q;
  hfr_pkg::prefix_t prefix_q;
  logic        rd_valid_q;
  logic        rd_oor_q;
  logic [7:0]  rd_mem_q;

  assign crc_next = hfr_pkg::crc_byte(crc_q, line_byte_i);

  always_comb begin
    in_frame_d = in_frame_q;
    count_d    = count_q;
    crc_d      = crc_q;
    store      = 1'b0;
    close_d    = '0;
    close_d.count  = 11'(count_q);
    close_d.crc_ok = (crc_q == hfr_pkg::CrcResidue);
    if (accept_i && !mode_i) begin
      if (!in_frame_q) begin
        if (line_byte_i == hfr_pkg::FlagByte) begin
          in_frame_d = 1'b1;
          count_d    = '0;
          crc_d      = hfr_pkg::CrcInit;
        end
      end else if (line_byte_i == hfr_pkg::FlagByte) begin
        if (count_q != '0) begin
          close_d.valid = 1'b1;
          in_frame_d    = 1'b0;
        end
      end else if (count_q < CW'(BUF_BYTES)) begin
        store   = 1'b1;
        crc_d   = crc_next;
        count_d = count_q + CW'(1);
      end else begin
        // overflow: drop and hunt again
        in_frame_d = 1'b0;
        count_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      count_q    <= '0;
      crc_q      <= hfr_pkg::CrcInit;
      close_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      in_frame_q <= in_frame_d;
      count_q    <= count_d;
      crc_q      <= crc_d;
      close_q    <= close_d;
      rd_valid_q <= accept_i && mode_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      mem_q[count_q[AW-1:0]] <= line_byte_i;
    end
    if (accept_i && mode_i) begin
      rd_mem_q <= mem_q[AW'(read_index_i)];
      rd_oor_q <= (32'(read_index_i) >= BUF_BYTES);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < hfr_pkg::HdrBytes; k++) begin
      if (store && (32'(count_q) == k)) begin
        hdr_q[k] <= line_byte_i;
      end
    end
    for (int k = 0; k < hfr_pkg::PrefixDepth; k++) begin
      if (store && (32'(count_q) == k)) begin
        prefix_q[k] <= crc_next;
      end
    end
  end

  assign close_o    = close_q;
  assign hdr_o      = hdr_q;
  assign prefix_o   = prefix_q;
  assign rd_valid_o = rd_valid_q;
  assign rd_data_o  = rd_oor_q ? 8'h00 : rd_mem_q;

endmodule

### rtl/hfr_check.sv
// Close-of-frame checker: format, addresses, HCS, class and payload span.
module hfr_check (
  input  hfr_pkg::close_t  close_i,
  input  hfr_pkg::hdr_t    hdr_i,
  input  hfr_pkg::prefix_t prefix_i,
  output logic             pass_o,
  output hfr_pkg::result_t report_o
);

  typedef struct packed {
    logic [2:0]  len;
    logic [14:0] val;
  } addr_t;

  function automatic addr_t decode_at(hfr_pkg::hdr_t h, logic [3:0] p, logic [10:0] n);
    addr_t       r;
    logic [10:0] avail;
    r     = '0;
    avail = (n > {7'd0, p}) ? (n - {7'd0, p}) : 11'd0;
    if (avail >= 11'd1) begin
      if (h[p][0]) begin
        r.len = 3'd1;
        r.val = {8'd0, h[p][7:1]};
      end else if (avail >= 11'd2 && h[4'(p + 4'd1)][0]) begin
        r.len = 3'd2;
        r.val = {h[p][7:1], 1'b0, h[4'(p + 4'd1)][7:1]};
      end else if (avail >= 11'd4 && h[4'(p + 4'd3)][0]) begin
        r.len = 3'd4;
        r.val = {h[p][7:1], 1'b0, h[4'(p + 4'd3)][7:1]};
      end
    end
    return r;
  endfunction

  logic [10:0] n;
  logic [15:0] format;
  addr_t       dst, src;
  logic [3:0]  src_pos, off, off2;
  logic [7:0]  ctrl;
  logic        with_info;
  logic [15:0] hcs_rx, hcs_calc;
  logic [10:0] rem;
  hfr_pkg::ftype_e ftype;
  logic [2:0]  ns, nr;
  logic [10:0] istart, ilen;
  logic        ok;

  always_comb begin
    n        = close_i.count;
    format   = {hdr_i[0], hdr_i[1]};
    ok       = (n >= 11'(hfr_pkg::MinFrame)) && close_i.crc_ok &&
               (format[15:12] == hfr_pkg::FormatType) && (format[10:0] == n);
    dst      = decode_at(hdr_i, 4'd2, n);
    src_pos  = 4'd2 + {1'b0, dst.len};
    src      = decode_at(hdr_i, src_pos, n);
    off      = src_pos + {1'b0, src.len};
    if (dst.len == 3'd0 || src.len == 3'd0 || {7'd0, off} >= n) begin
      ok = 1'b0;
    end
    ctrl      = (off < 4'(hfr_pkg::HdrBytes)) ? hdr_i[off] : 8'h00;
    with_info = n > ({7'd0, off} + 11'd5);
    hcs_rx    = {hdr_i[4'(off + 4'd2)], hdr_i[4'(off + 4'd1)]};
    hcs_calc  = (off < 4'(hfr_pkg::PrefixDepth)) ? ~prefix_i[off] : 16'h0000;
    if (with_info && hcs_rx != hcs_calc) begin
      ok = 1'b0;
    end
    off2 = with_info ? 4'(off + 4'd3) : 4'(off + 4'd1);

    ns = 3'd0;
    nr = 3'd0;
    if (!ctrl[0]) begin
      ftype = hfr_pkg::FT_I;
      ns    = ctrl[3:1];
      nr    = ctrl[7:5];
    end else if (!ctrl[1]) begin
      ftype = hfr_pkg::FT_SUPER;
      nr    = ctrl[7:5];
    end else if (ctrl == hfr_pkg::CtrlSnrm) begin
      ftype = hfr_pkg::FT_SNRM;
    end else if (ctrl == hfr_pkg::CtrlDisc) begin
      ftype = hfr_pkg::FT_DISC;
    end else if (ctrl == hfr_pkg::CtrlUi) begin
      ftype = hfr_pkg::FT_UI;
    end else begin
      ftype = hfr_pkg::FT_UNKNOWN;
    end

    rem    = n - {7'd0, off2} - 11'd2;
    istart = '0;
    ilen   = '0;
    if (with_info && (ftype == hfr_pkg::FT_I || ftype == hfr_pkg::FT_UI)) begin
      // skip the LLC header when present
      if (rem >= 11'd3 && hdr_i[off2] == hfr_pkg::LlcDestByte) begin
        istart = {7'd0, off2} + 11'd3;
        ilen   = rem - 11'd3;
      end else begin
        istart = {7'd0, off2};
        ilen   = rem;
      end
    end

    report_o              = '0;
    report_o.result_kind  = hfr_pkg::KIND_FRAME;
    report_o.frame_type   = ftype;
    report_o.dst_addr     = dst.val;
    report_o.src_addr     = src.val[6:0];
    report_o.control      = ctrl;
    report_o.tx_seq       = ns;
    report_o.rx_seq       = nr;
    report_o.segmented    = format[11];
    report_o.frame_length = format[9:0];
    report_o.info_start   = istart[9:0];
    report_o.info_length  = ilen[9:0];
    pass_o = close_i.valid && ok;
  end

endmodule

### rtl/hfr_fifo.sv
// Result queue between the intake side and the output port.
module hfr_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  hfr_pkg::result_t push_data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output hfr_pkg::result_t data_o,
  output logic [$clog2(hfr_pkg::FifoDepth+1)-1:0] count_o
);

  localparam int unsigned PW = $clog2(hfr_pkg::FifoDepth);
  localparam int unsigned NW = $clog2(hfr_pkg::FifoDepth + 1);

  hfr_pkg::result_t mem_q [hfr_pkg::FifoDepth];
  logic [PW-1:0] wr_q, rd_q;
  logic [NW-1:0] cnt_q;
  logic          do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + PW'(1);
      end
      cnt_q <= cnt_q + NW'(push_i) - NW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign count_o = cnt_q;

endmodule

### rtl/hdlc_frame_receiver.sv
// Top level of the HDLC frame receiver.
//
//   channel | signals                                   | direction
//   in      | in_valid_i / in_ready_o, mode, byte, index | line bytes and buffer reads in
//   out     | out_valid_o / out_ready_i, result fields   | frame reports and read data out
//
// One item is taken per cycle while in_ready_o is high; its result is pushed into the queue in the next cycle.
// Ready drops when the four-entry queue plus the item in flight would be full.
// Reset clears hunting state, count, CRC and queue; the buffer is not cleared.
// A stalled output only stalls input once the queue plus the item in flight fill it.
module hdlc_frame_receiver #(
  parameter int unsigned BUF_BYTES = hfr_pkg::BufBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [7:0]  line_byte_i,
  input  logic [9:0]  read_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [2:0]  frame_type_o,
  output logic [14:0] dst_addr_o,
  output logic [6:0]  src_addr_o,
  output logic [7:0]  control_o,
  output logic [2:0]  tx_seq_o,
  output logic [2:0]  rx_seq_o,
  output logic        segmented_o,
  output logic [9:0]  frame_length_o,
  output logic [9:0]  info_start_o,
  output logic [9:0]  info_length_o,
  output logic [7:0]  read_data_o
);

  localparam int unsigned NW = $clog2(hfr_pkg::FifoDepth + 1);

  logic             accept;
  hfr_pkg::close_t  close;
  hfr_pkg::hdr_t    hdr;
  hfr_pkg::prefix_t prefix;
  logic             rd_valid;
  logic [7:0]       rd_data;
  logic             pass;
  hfr_pkg::result_t report, push_data, head;
  logic             push;
  logic [NW-1:0]    fifo_cnt;
  logic             in_flight;

  assign in_flight  = close.valid || rd_valid;
  assign in_ready_o = (32'(fifo_cnt) + 32'(in_flight)) < hfr_pkg::FifoDepth;
  assign accept     = in_valid_i && in_ready_o;

  hfr_intake #(
    .BUF_BYTES(BUF_BYTES)
  ) u_intake (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .mode_i      (mode_i),
    .line_byte_i (line_byte_i),
    .read_index_i(read_index_i),
    .close_o     (close),
    .hdr_o       (hdr),
    .prefix_o    (prefix),
    .rd_valid_o  (rd_valid),
    .rd_data_o   (rd_data)
  );

  hfr_check u_check (
    .close_i (close),
    .hdr_i   (hdr),
    .prefix_i(prefix),
    .pass_o  (pass),
    .report_o(report)
  );

  always_comb begin
    push_data = report;
    if (rd_valid) begin
      push_data             = '0;
      push_data.result_kind = hfr_pkg::KIND_READ;
      push_data.read_data   = rd_data;
    end
  end

  assign push = rd_valid || pass;

  hfr_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (out_ready_i),
    .valid_o    (out_valid_o),
    .data_o     (head),
    .count_o    (fifo_cnt)
  );

  assign result_kind_o  = head.result_kind;
  assign frame_type_o   = head.frame_type;
  assign dst_addr_o     = head.dst_addr;
  assign src_addr_o     = head.src_addr;
  assign control_o      = head.control;
  assign tx_seq_o       = head.tx_seq;
  assign rx_seq_o       = head.rx_seq;
  assign segmented_o    = head.segmented;
  assign frame_length_o = head.frame_length;
  assign info_start_o   = head.info_start;
  assign info_length_o  = head.info_length;
  assign read_data_o    = head.read_data;

endmodule

### dv/hdlc_frame_receiver_tb.sv
// Self-checking testbench for the HDLC frame receiver: framed traffic, reads and checks.
module hdlc_frame_receiver_tb;

  localparam int unsigned BufLen = 1024;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        mode_i = 1'b0;
  logic [7:0]  line_byte_i = 8'h00;
  logic [9:0]  read_index_i = 10'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        result_kind_o;
  logic [2:0]  frame_type_o;
  logic [14:0] dst_addr_o;
  logic [6:0]  src_addr_o;
  logic [7:0]  control_o;
  logic [2:0]  tx_seq_o;
  logic [2:0]  rx_seq_o;
  logic        segmented_o;
  logic [9:0]  frame_length_o;
  logic [9:0]  info_start_o;
  logic [9:0]  info_length_o;
  logic [7:0]  read_data_o;

  hdlc_frame_receiver u_dut (.*);

  always #5 clk_i = ~clk_i;

  // Receiver state mirror
  logic        rx_open;
  int unsigned rx_count;
  logic [7:0]  rx_buf [BufLen];
  logic        rx_written [BufLen];
  logic [15:0] rx_crc;
  logic [15:0] rx_prefix [hfr_pkg::PrefixDepth];

  hfr_pkg::result_t pending_results [$];
  int unsigned errors = 0;
  int unsigned frames_seen = 0;
  int unsigned reads_seen = 0;
  int unsigned items_sent = 0;
  bit          idle_on = 1'b1;
  bit          stall_on = 1'b1;
  byte unsigned fb [$];

  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
    return c;
  endfunction

  // Address decode at pos; returns byte count, 0 if bad
  function automatic int unsigned addr_decode(int unsigned pos, output logic [14:0] val);
    int unsigned avail;
    avail = (pos < rx_count) ? rx_count - pos : 0;
    val = '0;
    if (avail < 1) return 0;
    if (rx_buf[pos][0]) begin
      val = {8'h00, rx_buf[pos][7:1]};
      return 1;
    end
    if (avail >= 2 && rx_buf[pos+1][0]) begin
      val = {rx_buf[pos][7:1], 1'b0, rx_buf[pos+1][7:1]};
      return 2;
    end
    if (avail >= 4 && rx_buf[pos+3][0]) begin
      val = {rx_buf[pos][7:1], 1'b0, rx_buf[pos+3][7:1]};
      return 4;
    end
    return 0;
  endfunction

  function automatic bit frame_check(output hfr_pkg::result_t r);
    logic [15:0] fmt, rx_hcs;
    logic [14:0] dst, srcv;
    int unsigned off, len, hdr, rem;
    logic [7:0] ctl;
    bit with_info;
    r = '0;
    rx_open = 1'b0;
    if (rx_count < hfr_pkg::MinFrame) return 0;
    if (rx_crc != hfr_pkg::CrcResidue) return 0;
    fmt = {rx_buf[0], rx_buf[1]};
    if (fmt[15:12] != hfr_pkg::FormatType) return 0;
    if (fmt[10:0] != rx_count) return 0;
    off = 2;
    len = addr_decode(off, dst);
    if (len == 0) return 0;
    off += len;
    len = addr_decode(off, srcv);
    if (len == 0) return 0;
    off += len;
    if (off >= rx_count) return 0;
    ctl = rx_buf[off];
    off++;
    hdr = off;
    with_info = rx_count > hdr + 4;
    if (with_info) begin
      rx_hcs = {rx_buf[off+1], rx_buf[off]};
      if ((rx_prefix[(hdr-1) % hfr_pkg::PrefixDepth] ^ 16'hFFFF) != rx_hcs) return 0;
      off += 2;
    end
    r.result_kind = hfr_pkg::KIND_FRAME;
    if (!ctl[0]) begin
      r.frame_type = hfr_pkg::FT_I;
      r.tx_seq = ctl[3:1];
      r.rx_seq = ctl[7:5];
    end else if (ctl[1:0] == 2'b01) begin
      r.frame_type = hfr_pkg::FT_SUPER;
      r.rx_seq = ctl[7:5];
    end else if (ctl == hfr_pkg::CtrlSnrm) r.frame_type = hfr_pkg::FT_SNRM;
    else if (ctl == hfr_pkg::CtrlDisc) r.frame_type = hfr_pkg::FT_DISC;
    else if (ctl == hfr_pkg::CtrlUi) r.frame_type = hfr_pkg::FT_UI;
    else r.frame_type = hfr_pkg::FT_UNKNOWN;
    if (with_info && (r.frame_type == hfr_pkg::FT_I || r.frame_type == hfr_pkg::FT_UI)) begin
      rem = rx_count - off - 2;
      if (rem >= 3 && rx_buf[off] == hfr_pkg::LlcDestByte) begin
        r.info_start = 10'(off + 3);
        r.info_length = 10'(rem - 3);
      end else begin
        r.info_start = 10'(off);
        r.info_length = 10'(rem);
      end
    end
    r.dst_addr = dst;
    r.src_addr = srcv[6:0];
    r.control = ctl;
    r.segmented = fmt[11];
    r.frame_length = fmt[9:0];
    return 1;
  endfunction

  // Advance the mirror by one accepted item
  function automatic void receiver_step(logic md, logic [7:0] b, logic [9:0] idx);
    hfr_pkg::result_t r;
    if (md) begin
      r = '0;
      r.result_kind = hfr_pkg::KIND_READ;
      r.read_data = rx_buf[idx];
      pending_results.push_back(r);
      return;
    end
    if (!rx_open) begin
      if (b == hfr_pkg::FlagByte) begin
        rx_open = 1'b1;
        rx_count = 0;
        rx_crc = hfr_pkg::CrcInit;
      end
      return;
    end
    if (b == hfr_pkg::FlagByte) begin
      if (rx_count == 0) return;
      if (frame_check(r)) pending_results.push_back(r);
      return;
    end
    if (rx_count < BufLen) begin
      rx_buf[rx_count] = b;
      rx_written[rx_count] = 1'b1;
      rx_crc = crc_step(rx_crc, b);
      if (rx_count < hfr_pkg::PrefixDepth) rx_prefix[rx_count] = rx_crc;
      rx_count++;
    end else begin
      rx_open = 1'b0;
      rx_count = 0;
    end
  endfunction

  // Drop valid only while idling, so each beat edge sees one assignment
  task automatic send_item(logic md, logic [7:0] b, logic [9:0] idx);
    while (idle_on && $urandom_range(99) < 22) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= md;
    line_byte_i <= b;
    read_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    receiver_step(md, b, idx);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(1'b0, b, 10'($urandom));
  endtask

  task automatic read_byte(int unsigned idx);
    send_item(1'b1, 8'($urandom), 10'(idx));
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      hfr_pkg::result_t r;
      if (pending_results.size() == 0) begin
        $error("unexpected result beat kind=%0d", result_kind_o);
        errors++;
      end else begin
        r = pending_results.pop_front();
        if (r.result_kind == hfr_pkg::KIND_READ) reads_seen++; else frames_seen++;
        if (result_kind_o !== r.result_kind) begin
          $error("result_kind exp %0d got %0d", r.result_kind, result_kind_o); errors++;
        end
        if (frame_type_o !== r.frame_type) begin
          $error("frame_type exp %0d got %0d", r.frame_type, frame_type_o); errors++;
        end
        if (dst_addr_o !== r.dst_addr) begin
          $error("dst_addr exp %h got %h", r.dst_addr, dst_addr_o); errors++;
        end
        if (src_addr_o !== r.src_addr) begin
          $error("src_addr exp %h got %h", r.src_addr, src_addr_o); errors++;
        end
        if (control_o !== r.control) begin
          $error("control exp %h got %h", r.control, control_o); errors++;
        end
        if (tx_seq_o !== r.tx_seq) begin
          $error("tx_seq exp %0d got %0d", r.tx_seq, tx_seq_o); errors++;
        end
        if (rx_seq_o !== r.rx_seq) begin
          $error("rx_seq exp %0d got %0d", r.rx_seq, rx_seq_o); errors++;
        end
        if (segmented_o !== r.segmented) begin
          $error("segmented exp %0d got %0d", r.segmented, segmented_o); errors++;
        end
        if (frame_length_o !== r.frame_length) begin
          $error("frame_length exp %0d got %0d", r.frame_length, frame_length_o); errors++;
        end
        if (info_start_o !== r.info_start) begin
          $error("info_start exp %0d got %0d", r.info_start, info_start_o); errors++;
        end
        if (info_length_o !== r.info_length) begin
          $error("info_length exp %0d got %0d", r.info_length, info_length_o); errors++;
        end
        if (read_data_o !== r.read_data) begin
          $error("read_data exp %h got %h", r.read_data, read_data_o); errors++;
        end
      end
    end
    out_ready_i <= !stall_on || ($urandom_range(99) >= 22);
  end

  // Random payload byte that is never a flag
  function automatic logic [7:0] data_byte();
    logic [7:0] v;
    v = 8'($urandom);
    if (v == hfr_pkg::FlagByte) v = 8'h7D;
    return v;
  endfunction

  // Push an address of alen bytes (1, 2 or 4) with random content
  task automatic push_addr(int unsigned alen);
    for (int i = 0; i < alen; i++) fb.push_back({7'($urandom), i == alen - 1 ? 1'b1 : 1'b0});
  endtask

  // Append the CRC of everything in fb, low byte first
  task automatic append_crc();
    logic [15:0] c;
    c = hfr_pkg::CrcInit;
    foreach (fb[i]) c = crc_step(c, fb[i]);
    c = c ^ 16'hFFFF;
    fb.push_back(c[7:0]);
    fb.push_back(c[15:8]);
  endtask

  // Build a frame into fb: format, addresses, control, optional HCS + info, FCS
  task automatic build_frame(int unsigned dlen, int unsigned slen, logic [7:0] ctl,
                             int unsigned pay_len, bit llc, bit seg);
    int unsigned total;
    fb.delete();
    total = 2 + dlen + slen + 1 + (pay_len > 0 ? 2 + pay_len : 0) + 2;
    fb.push_back({4'hA, seg, total[10:8]});
    fb.push_back(total[7:0]);
    push_addr(dlen);
    push_addr(slen);
    fb.push_back(ctl);
    if (pay_len > 0) begin
      append_crc();
      for (int i = 0; i < pay_len; i++)
        fb.push_back((llc && i == 0) ? hfr_pkg::LlcDestByte : data_byte());
    end
    append_crc();
  endtask

  // Send fb between flags; flag bytes inside the body break the frame, which is allowed
  task automatic send_frame();
    send_byte(hfr_pkg::FlagByte);
    foreach (fb[i]) send_byte(fb[i]);
    send_byte(hfr_pkg::FlagByte);
  endtask

  function automatic logic [7:0] random_ctl();
    case ($urandom_range(5))
      0: return 8'($urandom) & 8'hFE;
      1: return {3'($urandom), 1'($urandom), 2'($urandom), 2'b01};
      2: return hfr_pkg::CtrlSnrm;
      3: return hfr_pkg::CtrlDisc;
      4: return hfr_pkg::CtrlUi;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic read_written();
    int unsigned idx;
    idx = $urandom_range(BufLen - 1);
    for (int k = 0; k < 4 && !rx_written[idx]; k++) idx = $urandom_range(BufLen - 1);
    if (!rx_written[idx]) idx = 0;
    read_byte(idx);
  endtask

  task automatic test_directed();
    logic [7:0] ctls [6];
    ctls = '{8'h00, 8'hF1, hfr_pkg::CtrlSnrm, hfr_pkg::CtrlDisc, hfr_pkg::CtrlUi, 8'hFF};
    send_byte(8'h55);             // noise while hunting
    send_byte(hfr_pkg::FlagByte);
    send_byte(hfr_pkg::FlagByte); // repeated flag
    for (int i = 0; i < 6; i++) begin
      build_frame(1 + (i % 3 == 2 ? 3 : i % 2), 1, ctls[i], (i % 2) ? 0 : 5, i == 4, i == 0);
      send_frame();
    end
    build_frame(2, 1, 8'hFE, 3, 1'b1, 1'b1);
    send_frame();
    read_byte(0);
    read_byte(1);
  endtask

  task automatic test_rejects();
    // short frame, bad FCS, bad format, bad HCS, unterminated address
    fb = '{8'hA0, 8'h05, 8'h03};
    send_frame();
    build_frame(1, 1, 8'h10, 4, 1'b0, 1'b0);
    fb[fb.size()-1] ^= 8'h01;
    send_frame();
    build_frame(1, 1, hfr_pkg::CtrlUi, 0, 1'b0, 1'b0);
    fb[0] = 8'hB0;
    send_frame();
    build_frame(1, 1, hfr_pkg::CtrlUi, 4, 1'b0, 1'b0);
    fb[6] ^= 8'h80;
    // keep the FCS good so only the HCS fails
    void'(fb.pop_back());
    void'(fb.pop_back());
    append_crc();
    send_frame();
    fb = '{8'hA0, 8'h08, 8'h02, 8'h04, 8'h06, 8'h08, 8'h10, 8'h00};
    send_frame();
  endtask

  task automatic test_large();
    // frame that fills the whole buffer
    build_frame(4, 1, 8'h00, BufLen - 12, 1'b1, 1'b0);
    send_frame();
    read_byte(rx_written[BufLen - 1] ? BufLen - 1 : 0);
  endtask

  task automatic test_random(int unsigned n_items);
    int unsigned start, sel;
    start = items_sent;
    while (items_sent - start < n_items) begin
      if (items_sent - start > n_items / 4 && items_sent - start < n_items / 4 + 100) begin
        idle_on = 1'b0;
        stall_on = 1'b0;
      end else begin
        idle_on = 1'b1;
        stall_on = 1'b1;
      end
      sel = $urandom_range(99);
      if (sel < 65) begin
        build_frame(2 ** $urandom_range(2) == 1 ? 1 : (2 ** $urandom_range(2)),
                    2 ** $urandom_range(2), random_ctl(),
                    $urandom_range(3) == 0 ? 0 : $urandom_range(1, 12),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
        if ($urandom_range(9) == 0) fb[$urandom_range(fb.size() - 1)] ^= 8'(1 << $urandom_range(7));
        send_frame();
      end else if (sel < 85) begin
        read_written();
      end else begin
        send_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < BufLen; i++) begin
      rx_buf[i] = 8'h00;
      rx_written[i] = 1'b0;
    end
    for (int i = 0; i < hfr_pkg::PrefixDepth; i++) rx_prefix[i] = 16'h0000;
    rx_open = 1'b0;
    rx_count = 0;
    rx_crc = hfr_pkg::CrcInit;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_rejects();
    test_large();
    test_random(200);
    in_valid_i <= 1'b0;
    stall_on = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Sent %0d items; checked %0d frame reports and %0d buffer reads.",
             items_sent, frames_seen, reads_seen);
    if (errors == 0) $display("hdlc_frame_receiver_tb passed");
    else $display("hdlc_frame_receiver_tb failed");
    $finish;
  end

  initial begin
    #20000000;
    $display("hdlc_frame_receiver_tb failed");
    $finish;
  end

endmodule

### hdlc_frame_receiver.f
rtl/hfr_pkg.sv
rtl/hfr_intake.sv
rtl/hfr_check.sv
rtl/hfr_fifo.sv
rtl/hdlc_frame_receiver.sv
dv/hdlc_frame_receiver_tb.sv
